// File: rtl/core/lgi_pkg.sv
// ----------------------------------------------------------------------------
// lgi_pkg
// Shared types and constants of the load governor integrator.
// ----------------------------------------------------------------------------
package lgi_pkg;

  localparam int unsigned CostW   = 12;
  localparam int unsigned CountW  = 12;
  localparam int unsigned RungW   = 2;
  localparam int unsigned WinW    = 5;
  localparam int unsigned DebtW   = 14;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 14;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_DECIM_AUTO = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIN_AUTO   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TARGET     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BAND       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FIRE       = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE    = 3'd5;

  // reset values
  localparam logic [CostW-1:0]        TARGET_RST  = 12'd120;
  localparam logic [9:0]              BAND_RST    = 10'd30;
  localparam logic [12:0]             FIRE_RST    = 13'd1200;
  localparam logic signed [DebtW-1:0] RELEASE_RST = -14'sd2400;

  // window ladder
  localparam logic [WinW-1:0]   WIN_4     = 5'd4;
  localparam logic [WinW-1:0]   WIN_8     = 5'd8;
  localparam logic [WinW-1:0]   WIN_16    = 5'd16;
  localparam logic [CountW-1:0] UP_4_TO_8 = 12'd120;
  localparam logic [CountW-1:0] UP_8_TO16 = 12'd300;
  localparam logic [CountW-1:0] DN_8_TO_4 = 12'd100;
  localparam logic [CountW-1:0] DN_16TO_8 = 12'd260;

  localparam logic [RungW-1:0] RUNG_MAX = 2'd2;

  // debt math is done 16 bits wide, then clamped to 14
  localparam logic signed [15:0] DEBT_MAX = 16'sd8191;
  localparam logic signed [15:0] DEBT_MIN = -16'sd8192;

  typedef struct packed {
    logic               decim_auto;
    logic               win_auto;
    logic [CostW-1:0]   target;
    logic [9:0]         band;
    logic [12:0]        fire;
    logic signed [DebtW-1:0] release_lvl;
  } cfg_t;

  typedef struct packed {
    logic [CostW-1:0]  cost_tenths;
    logic [CountW-1:0] live_count;
    logic              demo_playback;
  } in_word_t;

  typedef struct packed {
    logic [RungW-1:0]        rung;
    logic [WinW-1:0]         window_tics;
    logic signed [DebtW-1:0] debt_value;
  } out_word_t;

endpackage

// File: rtl/core/lgi_window.sv
// ----------------------------------------------------------------------------
// lgi_window
// Window hysteresis ladder 4/8/16 driven by the live object count.
// ----------------------------------------------------------------------------
module lgi_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        auto_i,
  input  logic [lgi_pkg::CountW-1:0]  count_i,
  output logic [lgi_pkg::WinW-1:0]    win_o
);

  logic [lgi_pkg::WinW-1:0] win_q, win_d;

  always_comb begin
    win_d = win_q;
    if (auto_i) begin
      unique case (win_q)
        lgi_pkg::WIN_4: begin
          if (count_i >= lgi_pkg::UP_4_TO_8) win_d = lgi_pkg::WIN_8;
        end
        lgi_pkg::WIN_8: begin
          if (count_i >= lgi_pkg::UP_8_TO16) win_d = lgi_pkg::WIN_16;
          else if (count_i <= lgi_pkg::DN_8_TO_4) win_d = lgi_pkg::WIN_4;
        end
        default: begin
          if (count_i <= lgi_pkg::DN_16TO_8) win_d = lgi_pkg::WIN_8;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= lgi_pkg::WIN_4;
    end else if (step_i) begin
      win_q <= win_d;
    end
  end

  assign win_o = win_d;

endmodule

// File: rtl/core/lgi_decim.sv
// ----------------------------------------------------------------------------
// lgi_decim
// Cost debt integrator and decimation rung law.
// ----------------------------------------------------------------------------
module lgi_decim (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  lgi_pkg::cfg_t                     cfg_i,
  input  logic [lgi_pkg::CostW-1:0]         cost_i,
  input  logic                              playback_i,
  output logic [lgi_pkg::RungW-1:0]         rung_o,
  output logic signed [lgi_pkg::DebtW-1:0]  debt_o
);

  logic [lgi_pkg::RungW-1:0]        rung_q, rung_d;
  logic signed [lgi_pkg::DebtW-1:0] debt_q, debt_d;

  logic signed [15:0] err, band, over, under, debt_w, sum, sat, fire, rel;

  always_comb begin
    err    = $signed({4'b0, cost_i}) - $signed({4'b0, cfg_i.target});
    band   = $signed({6'b0, cfg_i.band});
    over   = err - band;
    under  = -(err + band);
    debt_w = {{2{debt_q[lgi_pkg::DebtW-1]}}, debt_q};
    fire   = $signed({3'b0, cfg_i.fire});
    rel    = {{2{cfg_i.release_lvl[lgi_pkg::DebtW-1]}}, cfg_i.release_lvl};

    priority if (err > band) begin
      sum = debt_w + over;
    end else if (err < -band) begin
      // under is positive here, halving truncates toward zero
      sum = debt_w - (under >>> 1);
    end else begin
      sum = debt_w;
    end

    priority if (sum > lgi_pkg::DEBT_MAX) begin
      sat = lgi_pkg::DEBT_MAX;
    end else if (sum < lgi_pkg::DEBT_MIN) begin
      sat = lgi_pkg::DEBT_MIN;
    end else begin
      sat = sum;
    end

    rung_d = rung_q;
    debt_d = debt_q;
    if (playback_i) begin
      rung_d = '0;
    end else if (cfg_i.decim_auto) begin
      debt_d = sat[lgi_pkg::DebtW-1:0];
      priority if (sat >= fire) begin
        if (rung_q < lgi_pkg::RUNG_MAX) rung_d = rung_q + 2'd1;
        debt_d = '0;
      end else if (sat <= rel) begin
        if (rung_q != '0) rung_d = rung_q - 2'd1;
        debt_d = '0;
      end else begin
        debt_d = sat[lgi_pkg::DebtW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rung_q <= '0;
      debt_q <= '0;
    end else if (step_i) begin
      rung_q <= rung_d;
      debt_q <= debt_d;
    end
  end

  assign rung_o = rung_d;
  assign debt_o = debt_d;

endmodule

// File: rtl/core/load_governor_integrator.sv
// ----------------------------------------------------------------------------
// load_governor_integrator
// Per-tick load governor: window ladder plus cost debt decimation law.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one word per tick (cost, live count, playback flag).
//   out channel : one word per input word (rung, window, debt after the step).
//   cfg channel : register index and data, always ready; write only while
//                 the block is idle.
// Path: an accepted word goes to the input register, its result to the
//   result register, which drives out_word_o.
// Throughput: one word per cycle while out_ready_i is high; the state
//   update is a single pass of adds and compares, input to result register.
// Reset: config registers return to defaults, debt and rung clear,
//   window returns to 4, both valid flags drop.
// Stall: while out_ready_i is low the result holds; one more word waits in
//   the input register, after which in_ready_o drops.
// ----------------------------------------------------------------------------
module load_governor_integrator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lgi_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lgi_pkg::out_word_t            out_word_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lgi_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lgi_pkg::CfgW-1:0]      cfg_data_i
);

  lgi_pkg::cfg_t      cfg_q;
  lgi_pkg::in_word_t  in_q;
  lgi_pkg::out_word_t out_q, out_d;
  logic               in_v_q, out_v_q;
  logic               out_load, step;

  assign out_load    = !out_v_q || out_ready_i;
  assign step        = in_v_q && out_load;
  assign in_ready_o  = !in_v_q || out_load;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decim_auto  <= 1'b1;
      cfg_q.win_auto    <= 1'b1;
      cfg_q.target      <= lgi_pkg::TARGET_RST;
      cfg_q.band        <= lgi_pkg::BAND_RST;
      cfg_q.fire        <= lgi_pkg::FIRE_RST;
      cfg_q.release_lvl <= lgi_pkg::RELEASE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lgi_pkg::CFG_DECIM_AUTO: cfg_q.decim_auto  <= cfg_data_i[0];
        lgi_pkg::CFG_WIN_AUTO:   cfg_q.win_auto    <= cfg_data_i[0];
        lgi_pkg::CFG_TARGET:     cfg_q.target      <= cfg_data_i[11:0];
        lgi_pkg::CFG_BAND:       cfg_q.band        <= cfg_data_i[9:0];
        lgi_pkg::CFG_FIRE:       cfg_q.fire        <= cfg_data_i[12:0];
        lgi_pkg::CFG_RELEASE:    cfg_q.release_lvl <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) in_v_q <= in_valid_i;
      if (out_load)   out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_word_i;
    if (step)                     out_q <= out_d;
  end

  lgi_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .auto_i  (cfg_q.win_auto),
    .count_i (in_q.live_count),
    .win_o   (out_d.window_tics)
  );

  lgi_decim u_decim (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .cfg_i      (cfg_q),
    .cost_i     (in_q.cost_tenths),
    .playback_i (in_q.demo_playback),
    .rung_o     (out_d.rung),
    .debt_o     (out_d.debt_value)
  );

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

endmodule

// File: rtl/core/lgi_checker.sv
// ----------------------------------------------------------------------------
// lgi_checker
// Port-level checks on the result channel of the load governor integrator.
// ----------------------------------------------------------------------------
module lgi_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input lgi_pkg::out_word_t out_word_o
);

  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed or dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.rung != 2'd3)
    else $error("rung out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.window_tics == lgi_pkg::WIN_4 ||
                     out_word_o.window_tics == lgi_pkg::WIN_8 ||
                     out_word_o.window_tics == lgi_pkg::WIN_16))
    else $error("window not 4, 8 or 16");

endmodule

bind load_governor_integrator lgi_checker u_lgi_checker (.*);

// File: tb/tb_load_governor_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_load_governor_integrator
// Self-checking bench for the per-tick load governor.
// Ticks go in over a valid/ready channel. A local predictor of the window
// ladder and the cost debt law gives the expected output word for each
// accepted tick, and each output word is compared field by field, in order.
// Directed ticks cover the ladder thresholds, playback, debt saturation and
// odd threshold settings. Random ticks then run under several register
// settings, with random idle bursts on both sides, then none at the end.
// ----------------------------------------------------------------------------
module tb_load_governor_integrator;

  localparam int unsigned CycleLimit = 400000;

  logic                        clk;
  logic                        rst_ni;
  logic                        in_valid;
  logic                        in_ready_o;
  lgi_pkg::in_word_t           in_word;
  logic                        out_valid_o;
  logic                        out_ready;
  lgi_pkg::out_word_t          out_word_o;
  logic                        cfg_valid;
  logic                        cfg_ready_o;
  logic [lgi_pkg::CfgIdxW-1:0] cfg_index;
  logic [lgi_pkg::CfgW-1:0]    cfg_data;

  bit                          idle_en;
  int                          stall_left;
  int                          fail_count;
  int unsigned                 cycle_count;
  lgi_pkg::out_word_t          pending_results[$];
  lgi_pkg::out_word_t          exp_word;

  // governor state and register copies
  bit                          m_decim_auto;
  bit                          m_win_auto;
  int                          m_target;
  int                          m_band;
  int                          m_fire;
  int                          m_release;
  int                          debt_acc;
  int                          rung_lvl;
  logic [lgi_pkg::WinW-1:0]    window_lvl;

  load_governor_integrator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // output stall bursts
  always @(posedge clk) begin
    if (!idle_en) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 12);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("output word with nothing expected");
        fail_count++;
      end else begin
        exp_word = pending_results.pop_front();
        if (out_word_o.rung !== exp_word.rung) begin
          $error("rung: expected %0d, got %0d", exp_word.rung, out_word_o.rung);
          fail_count++;
        end
        if (out_word_o.window_tics !== exp_word.window_tics) begin
          $error("window_tics: expected %0d, got %0d",
                 exp_word.window_tics, out_word_o.window_tics);
          fail_count++;
        end
        if (out_word_o.debt_value !== exp_word.debt_value) begin
          $error("debt_value: expected %0d, got %0d",
                 $signed(exp_word.debt_value), $signed(out_word_o.debt_value));
          fail_count++;
        end
      end
    end
  end

  function automatic lgi_pkg::out_word_t govern_step(input lgi_pkg::in_word_t w);
    int                 cost;
    int                 count;
    int                 err;
    int                 d;
    lgi_pkg::out_word_t r;
    cost  = int'(w.cost_tenths);
    count = int'(w.live_count);
    if (m_win_auto) begin
      case (window_lvl)
        lgi_pkg::WIN_4: begin
          if (count >= int'(lgi_pkg::UP_4_TO_8)) window_lvl = lgi_pkg::WIN_8;
        end
        lgi_pkg::WIN_8: begin
          if (count >= int'(lgi_pkg::UP_8_TO16)) window_lvl = lgi_pkg::WIN_16;
          else if (count <= int'(lgi_pkg::DN_8_TO_4)) window_lvl = lgi_pkg::WIN_4;
        end
        default: begin
          if (count <= int'(lgi_pkg::DN_16TO_8)) window_lvl = lgi_pkg::WIN_8;
        end
      endcase
    end
    if (w.demo_playback) begin
      rung_lvl = 0;
    end else if (m_decim_auto) begin
      err = cost - m_target;
      d   = debt_acc;
      if (err > m_band) begin
        d += err - m_band;
      end else if (err < -m_band) begin
        d -= (-(err + m_band)) / 2;
      end
      if (d > 8191) d = 8191;
      if (d < -8192) d = -8192;
      if (d >= m_fire) begin
        if (rung_lvl < int'(lgi_pkg::RUNG_MAX)) rung_lvl++;
        d = 0;
      end else if (d <= m_release) begin
        if (rung_lvl > 0) rung_lvl--;
        d = 0;
      end
      debt_acc = d;
    end
    r.rung        = rung_lvl[lgi_pkg::RungW-1:0];
    r.window_tics = window_lvl;
    r.debt_value  = debt_acc[lgi_pkg::DebtW-1:0];
    return r;
  endfunction

  function automatic lgi_pkg::in_word_t mk_word(input int cost, input int count,
                                                input bit pb);
    lgi_pkg::in_word_t w;
    w.cost_tenths   = cost[lgi_pkg::CostW-1:0];
    w.live_count    = count[lgi_pkg::CountW-1:0];
    w.demo_playback = pb;
    return w;
  endfunction

  function automatic lgi_pkg::in_word_t rand_word();
    int lo;
    int hi;
    int cost;
    int count;
    int pick;
    case ($urandom_range(0, 9))
      0, 1:    cost = $urandom_range(0, 4095);
      2:       cost = $urandom_range(0, 1) ? 4095 : 0;
      default: begin
        lo   = m_target - m_band - 60;
        hi   = m_target + m_band + 60;
        lo   = (lo < 0) ? 0 : lo;
        hi   = (hi > 4095) ? 4095 : hi;
        cost = $urandom_range(lo, hi);
      end
    endcase
    if ($urandom_range(0, 4) == 0) begin
      count = $urandom_range(0, 4095);
    end else begin
      case ($urandom_range(0, 3))
        0:       pick = int'(lgi_pkg::DN_8_TO_4);
        1:       pick = int'(lgi_pkg::UP_4_TO_8);
        2:       pick = int'(lgi_pkg::DN_16TO_8);
        default: pick = int'(lgi_pkg::UP_8_TO16);
      endcase
      count = pick + $urandom_range(0, 50) - 25;
    end
    return mk_word(cost, count, $urandom_range(0, 15) == 0);
  endfunction

  task automatic send_word(input lgi_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready_o);
    pending_results.push_back(govern_step(w));
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send(input int cost, input int count, input bit pb);
    send_word(mk_word(cost, count, pb));
  endtask

  task automatic run_random(input int n);
    repeat (n) send_word(rand_word());
  endtask

  // stop sending and let every expected word come out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lgi_pkg::CfgIdxW-1:0] idx, input int value);
    logic [lgi_pkg::CfgW-1:0] d;
    d = value[lgi_pkg::CfgW-1:0];
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      lgi_pkg::CFG_DECIM_AUTO: m_decim_auto = d[0];
      lgi_pkg::CFG_WIN_AUTO:   m_win_auto   = d[0];
      lgi_pkg::CFG_TARGET:     m_target     = int'(d[lgi_pkg::CostW-1:0]);
      lgi_pkg::CFG_BAND:       m_band       = int'(d[9:0]);
      lgi_pkg::CFG_FIRE:       m_fire       = int'(d[12:0]);
      lgi_pkg::CFG_RELEASE:    m_release    = int'($signed(d));
      default: ;
    endcase
  endtask

  task automatic program_regs(input bit decim, input bit win, input int target,
                              input int band, input int fire, input int rel);
    settle();
    write_reg(lgi_pkg::CFG_DECIM_AUTO, decim);
    write_reg(lgi_pkg::CFG_WIN_AUTO, win);
    write_reg(lgi_pkg::CFG_TARGET, target);
    write_reg(lgi_pkg::CFG_BAND, band);
    write_reg(lgi_pkg::CFG_FIRE, fire);
    write_reg(lgi_pkg::CFG_RELEASE, rel);
    cfg_valid <= 1'b0;
  endtask

  // reset defaults; walks the window ladder across every threshold
  task automatic test_window_ladder();
    send(0, 119, 0);
    send(4095, 120, 0);
    send(120, 299, 0);
    send(4095, 300, 1);
    send(150, 261, 0);
    send(151, 260, 0);
    send(89, 101, 0);
    send(88, 100, 0);
    send(0, 4095, 0);
    send(4095, 0, 0);
  endtask

  task automatic test_debt_saturation();
    program_regs(1'b1, 1'b0, 0, 0, 8191, -8192);
    repeat (3) send(4095, 4095, 0);
    program_regs(1'b1, 1'b1, 4095, 0, 8191, -8192);
    repeat (5) send(0, 200, 0);
  endtask

  // zero fire level, non-negative release level
  task automatic test_level_edges();
    program_regs(1'b1, 1'b1, 120, 30, 0, 5);
    send(120, 50, 0);
    send(0, 50, 0);
  endtask

  task automatic test_laws_disabled();
    program_regs(1'b0, 1'b0, 120, 30, 1200, -2400);
    send(4095, 4095, 0);
    send(0, 0, 0);
    send(4095, 300, 1);
  endtask

  task automatic test_random_settings();
    program_regs(1'b1, 1'b1, 120, 30, 1200, -2400);
    run_random(300);
    program_regs(1'b1, 1'b1, 0, 0, 1, -1);
    run_random(200);
    program_regs(1'b1, 1'b1, 4095, 1023, 8191, -8192);
    run_random(200);
    repeat (4) begin
      program_regs($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                   $urandom_range(0, 4095), $urandom_range(0, 1023),
                   $urandom_range(0, 1) ? $urandom_range(1, 400) : $urandom_range(1, 8191),
                   -int'($urandom_range(1, 8192)));
      run_random(150);
    end
  endtask

  task automatic test_sender_pause();
    program_regs(1'b1, 1'b1, 200, 20, 300, -300);
    repeat (5) begin
      run_random(20);
      settle();
    end
  endtask

  task automatic test_no_idle();
    program_regs(1'b1, 1'b1, 120, 30, 600, -900);
    idle_en = 1'b0;
    run_random(200);
  endtask

  initial begin
    clk          = 1'b0;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    out_ready    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    idle_en      = 1'b1;
    stall_left   = 0;
    fail_count   = 0;
    cycle_count  = 0;
    m_decim_auto = 1'b1;
    m_win_auto   = 1'b1;
    m_target     = 120;
    m_band       = 30;
    m_fire       = 1200;
    m_release    = -2400;
    debt_acc     = 0;
    rung_lvl     = 0;
    window_lvl   = lgi_pkg::WIN_4;
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_window_ladder();
    test_debt_saturation();
    test_level_edges();
    test_laws_disabled();
    test_random_settings();
    test_sender_pause();
    test_no_idle();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
